FILE: design/stt_pkg.sv
package stt_pkg;

  // Scan modes of the lexer, one-hot.
  typedef enum logic [11:0] {
    M_IDLE        = 12'b0000_0000_0001,
    M_NUM         = 12'b0000_0000_0010,
    M_NUM_OVF     = 12'b0000_0000_0100,
    M_NUM_DOT     = 12'b0000_0000_1000,
    M_NUM_DOT_OVF = 12'b0000_0001_0000,
    M_FRAC        = 12'b0000_0010_0000,
    M_IDENT       = 12'b0000_0100_0000,
    M_UNDER       = 12'b0000_1000_0000,
    M_OP          = 12'b0001_0000_0000,
    M_BIN         = 12'b0010_0000_0000,
    M_BIN_COLON   = 12'b0100_0000_0000,
    M_ERR         = 12'b1000_0000_0000
  } mode_e;

  localparam logic [5:0] K_END   = 6'd0;
  localparam logic [5:0] K_INT   = 6'd1;
  localparam logic [5:0] K_FLOAT = 6'd2;
  localparam logic [5:0] K_IDENT = 6'd3;
  localparam logic [5:0] K_TRUE  = 6'd13;
  localparam logic [5:0] K_SBYTE = 6'd15;
  localparam logic [5:0] K_SEND  = 6'd16;
  localparam logic [5:0] K_UNDER = 6'd17;
  localparam logic [5:0] K_CARET = 6'd20;
  localparam logic [5:0] K_LT    = 6'd24;
  localparam logic [5:0] K_MINUS = 6'd26;
  localparam logic [5:0] K_GT    = 6'd29;
  localparam logic [5:0] K_NOT   = 6'd44;
  localparam logic [5:0] K_LBRK  = 6'd32;
  localparam logic [5:0] K_ERROR = 6'd47;

  localparam logic [3:0] E_NONE    = 4'd0;
  localparam logic [3:0] E_CHAR    = 4'd1;
  localparam logic [3:0] E_EQ      = 4'd2;
  localparam logic [3:0] E_AMP     = 4'd3;
  localparam logic [3:0] E_BAR     = 4'd4;
  localparam logic [3:0] E_QUOTE   = 4'd5;
  localparam logic [3:0] E_BINCHAR = 4'd6;
  localparam logic [3:0] E_UNCLOSE = 4'd7;
  localparam logic [3:0] E_BITCNT  = 4'd8;
  localparam logic [3:0] E_OVF     = 4'd9;

  localparam logic [20:0] POS_MAX = 21'd1048576;

  // One result token.
  typedef struct packed {
    logic [5:0]  kind;
    logic [3:0]  err;
    logic [62:0] value;
    logic [20:0] line;
    logic [20:0] column;
    logic [19:0] offset;
    logic [20:0] length;
    logic        last;
  } token_t;

  // Work request from the front part to the back part.
  typedef struct packed {
    logic [1:0] count;
    token_t     tok0;
    token_t     tok1;
  } job_t;

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_digit(c) || is_alpha(c) || c == 8'h5f;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0d || c == 8'h0a;
  endfunction

  // Keyword lookup on the packed first bytes of an identifier.
  function automatic logic [5:0] kw_kind(input logic [63:0] b, input logic [3:0] n);
    logic [5:0] k;
    k = K_IDENT;
    unique case (n)
      4'd1: if (b == 64'h76) k = 6'd14;
      4'd3: begin
        if (b == 64'h696e74) k = 6'd4;
        else if (b == 64'h737472) k = 6'd7;
      end
      4'd4: begin
        if (b == 64'h626f6f6c) k = 6'd6;
        else if (b == 64'h62797465) k = 6'd8;
        else if (b == 64'h766f6964) k = 6'd9;
        else if (b == 64'h65786974) k = 6'd12;
        else if (b == 64'h74727565) k = 6'd13;
      end
      4'd5: begin
        if (b == 64'h666c6f6174) k = 6'd5;
        else if (b == 64'h627265616b) k = 6'd10;
        else if (b == 64'h66616c7365) k = 6'd14;
      end
      4'd8: if (b == 64'h636f6e74696e7565) k = 6'd11;
      default: k = K_IDENT;
    endcase
    return k;
  endfunction

  // Single-character tokens that need no lookahead; 0 means none.
  function automatic logic [5:0] single_kind(input logic [7:0] c);
    logic [5:0] k;
    unique case (c)
      8'h40: k = 6'd18;
      8'h23: k = 6'd19;
      8'h5e: k = 6'd20;
      8'h3f: k = 6'd30;
      8'h7e: k = 6'd31;
      8'h5d: k = 6'd33;
      8'h28: k = 6'd34;
      8'h29: k = 6'd35;
      8'h3b: k = 6'd36;
      8'h2c: k = 6'd37;
      8'h2b: k = 6'd38;
      8'h2a: k = 6'd39;
      8'h2f: k = 6'd40;
      8'h25: k = 6'd41;
      default: k = 6'd0;
    endcase
    return k;
  endfunction

  function automatic logic is_held_op(input logic [7:0] c);
    return c == 8'h3c || c == 8'h2d || c == 8'h3e || c == 8'h3d ||
           c == 8'h21 || c == 8'h26 || c == 8'h7c || c == 8'h5b;
  endfunction

  // Two-character operator after a held first character; 0 means none.
  function automatic logic [5:0] two_kind(input logic [7:0] h, input logic [7:0] c);
    logic [5:0] k;
    k = 6'd0;
    unique case (h)
      8'h3c: begin
        if (c == 8'h2d) k = 6'd21;
        else if (c == 8'h3f) k = 6'd22;
        else if (c == 8'h3d) k = 6'd23;
      end
      8'h2d: if (c == 8'h3e) k = 6'd25;
      8'h3e: begin
        if (c == 8'h3e) k = 6'd27;
        else if (c == 8'h3d) k = 6'd28;
      end
      8'h3d: if (c == 8'h3d) k = 6'd42;
      8'h21: if (c == 8'h3d) k = 6'd43;
      8'h26: if (c == 8'h26) k = 6'd45;
      8'h7c: if (c == 8'h7c) k = 6'd46;
      default: k = 6'd0;
    endcase
    return k;
  endfunction

endpackage

FILE: design/stt_if.sv
interface stt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_of_source;
  modport source (output valid, char_byte, end_of_source, input ready);
  modport sink (input valid, char_byte, end_of_source, output ready);
endinterface

interface stt_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  token_kind;
  logic [3:0]  error_code;
  logic [62:0] token_value;
  logic [20:0] start_line;
  logic [20:0] start_column;
  logic [19:0] start_offset;
  logic [20:0] token_length;
  logic        last_of_run;
  modport source (output valid, token_kind, error_code, token_value, start_line,
                  start_column, start_offset, token_length, last_of_run, input ready);
  modport sink (input valid, token_kind, error_code, token_value, start_line,
                start_column, start_offset, token_length, last_of_run, output ready);
endinterface

FILE: design/stt_front.sv
module stt_front #(
  parameter int unsigned SOURCE_BYTES  = 1048576,
  parameter int unsigned KEYWORD_CHARS = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    char_byte_i,
  input  logic          end_of_source_i,
  output logic          job_valid_o,
  input  logic          job_ready_i,
  output stt_pkg::job_t job_o
);
  import stt_pkg::*;

  localparam logic [19:0] OFF_MAX = (SOURCE_BYTES - 1 < 1048575) ?
                                    20'(SOURCE_BYTES - 1) : 20'hFFFFF;
  // Characters kept for keyword matching, and where the length count stops.
  localparam logic [3:0] KW_CAP  = (KEYWORD_CHARS < 8) ? 4'(KEYWORD_CHARS) : 4'd8;
  localparam logic [3:0] LEN_SAT = (KEYWORD_CHARS + 1 < 15) ?
                                   4'(KEYWORD_CHARS + 1) : 4'd15;

  mode_e       mode_q, mode_d;
  logic [7:0]  held_q, held_d;
  logic [20:0] line_q, line_d, col_q, col_d, sline_q, sline_d, scol_q, scol_d;
  logic [19:0] off_q, off_d, soff_q, soff_d;
  logic [62:0] acc_q, acc_d;
  logic [63:0] kw_q, kw_d;
  logic [3:0]  kwl_q, kwl_d;
  logic [7:0]  bits_q, bits_d;
  logic [2:0]  phase_q, phase_d;
  job_t        job;

  logic        fire;
  logic [7:0]  c;
  logic [20:0] pcol;
  logic [19:0] poff;
  logic [19:0] plen;
  logic [3:0]  d4;
  logic [66:0] mul10;
  logic        ovf;
  logic [7:0]  nbits;

  assign in_ready_o  = job_ready_i;
  assign fire        = in_valid_i && in_ready_o;
  assign job_valid_o = fire && job.count != 2'd0;
  assign job_o       = job;
  assign c           = char_byte_i;
  assign pcol        = (col_q > 21'd1) ? col_q - 21'd1 : 21'd1;
  assign poff        = (off_q > 20'd0) ? off_q - 20'd1 : 20'd0;
  // Span from the token start up to the previous byte, never below zero.
  assign plen        = (poff > soff_q) ? poff - soff_q : 20'd0;
  assign d4          = c[3:0];
  // Overflow when acc*10+d exceeds 2^63-1.
  assign mul10       = {4'd0, acc_q} * 67'd10 + {63'd0, d4};
  assign ovf         = mul10[66:63] != 4'd0;
  assign nbits       = {bits_q[6:0], c[0]};

  always_comb begin
    token_t t;
    logic   done;
    logic [5:0] sk, tk;
    mode_e  nm;
    mode_d = mode_q; held_d = held_q; line_d = line_q; col_d = col_q;
    off_d = off_q; sline_d = sline_q; scol_d = scol_q; soff_d = soff_q;
    acc_d = acc_q; kw_d = kw_q; kwl_d = kwl_q; bits_d = bits_q; phase_d = phase_q;
    job = '0;
    t = '0;
    done = 1'b0;
    sk = 6'd0;
    tk = 6'd0;
    nm = mode_q;

    // Token at the held start, ending at a given offset.
    if (!end_of_source_i && mode_q != M_ERR) begin
      // Pending token closed by this byte, if any.
      t.line = sline_q; t.column = scol_q; t.offset = soff_q;
      t.length = {1'b0, off_q - soff_q};
      unique case (mode_q)
        M_IDLE: done = 1'b0;
        M_NUM, M_NUM_OVF: begin
          if (is_digit(c)) begin
            if (mode_q == M_NUM) begin
              if (ovf) mode_d = M_NUM_OVF;
              else acc_d = mul10[62:0];
            end
          end else if (c == 8'h2e) begin
            mode_d = (mode_q == M_NUM) ? M_NUM_DOT : M_NUM_DOT_OVF;
          end else if (mode_q == M_NUM_OVF) begin
            t.kind = K_ERROR; t.err = E_OVF; mode_d = M_ERR;
            job.count = 2'd1; job.tok0 = t;
          end else begin
            t.kind = K_INT; t.value = acc_q; done = 1'b1;
          end
        end
        M_NUM_DOT, M_NUM_DOT_OVF: begin
          t.length = {1'b0, plen};
          if (is_digit(c)) mode_d = M_FRAC;
          else begin
            job.count = 2'd1;
            if (mode_q == M_NUM_DOT_OVF) begin
              t.kind = K_ERROR; t.err = E_OVF;
              job.tok0 = t;
            end else begin
              t.kind = K_INT; t.value = acc_q;
              job.tok0 = t;
              job.count = 2'd2;
              job.tok1 = '0;
              job.tok1.kind = K_ERROR; job.tok1.err = E_CHAR;
              job.tok1.line = line_q; job.tok1.column = pcol;
              job.tok1.offset = poff; job.tok1.length = 21'd1;
            end
            mode_d = M_ERR;
          end
        end
        M_FRAC: if (!is_digit(c)) begin
          t.kind = K_FLOAT; done = 1'b1;
        end
        M_IDENT: begin
          if (is_word(c)) begin
            if (kwl_q < KW_CAP) kw_d = {kw_q[55:0], c};
            if (kwl_q < LEN_SAT) kwl_d = kwl_q + 4'd1;
          end else begin
            t.kind = kw_kind(kw_q, kwl_q);
            if (t.kind == K_TRUE) t.value = 63'd1;
            done = 1'b1;
          end
        end
        M_UNDER: begin
          if (is_word(c)) begin
            kw_d = {48'd0, 8'h5f, c}; kwl_d = 4'd2; mode_d = M_IDENT;
          end else begin
            t.kind = K_UNDER; done = 1'b1;
          end
        end
        M_OP: begin
          t.length = 21'd1;
          tk = two_kind(held_q, c);
          if (tk != 6'd0) begin
            t.kind = tk; t.length = {1'b0, off_q - soff_q} + 21'd1; mode_d = M_IDLE;
            job.count = 2'd1; job.tok0 = t;
          end else if (held_q == 8'h5b && c == 8'h3a) begin
            bits_d = 8'd0; phase_d = 3'd0; mode_d = M_BIN;
          end else begin
            done = 1'b1;
            unique case (held_q)
              8'h3c: t.kind = K_LT;
              8'h2d: t.kind = K_MINUS;
              8'h3e: t.kind = K_GT;
              8'h21: t.kind = K_NOT;
              8'h5b: t.kind = K_LBRK;
              8'h3d: begin t.kind = K_ERROR; t.err = E_EQ; end
              8'h26: begin t.kind = K_ERROR; t.err = E_AMP; end
              default: begin t.kind = K_ERROR; t.err = E_BAR; end
            endcase
            if (t.kind == K_ERROR) begin
              done = 1'b0; mode_d = M_ERR;
              job.count = 2'd1; job.tok0 = t;
            end
          end
        end
        M_BIN: begin
          if (c == 8'h3a) mode_d = M_BIN_COLON;
          else if (c == 8'h30 || c == 8'h31) begin
            if (phase_q == 3'd7) begin
              t.kind = K_SBYTE; t.value = {55'd0, nbits};
              t.length = {1'b0, off_q - soff_q} + 21'd1;
              job.count = 2'd1; job.tok0 = t;
              bits_d = 8'd0; phase_d = 3'd0;
            end else begin
              bits_d = nbits; phase_d = phase_q + 3'd1;
            end
          end else if (!is_blank(c)) begin
            t.kind = K_ERROR; t.err = E_BINCHAR; t.line = line_q; t.column = col_q;
            t.offset = off_q; t.length = 21'd1;
            job.count = 2'd1; job.tok0 = t; mode_d = M_ERR;
          end
        end
        M_BIN_COLON: begin
          job.count = 2'd1; mode_d = M_ERR;
          if (c == 8'h5d) begin
            t.length = {1'b0, off_q - soff_q} + 21'd1;
            if (phase_q != 3'd0) begin t.kind = K_ERROR; t.err = E_BITCNT; end
            else begin t.kind = K_SEND; mode_d = M_IDLE; end
          end else begin
            t.kind = K_ERROR; t.err = E_BINCHAR; t.line = line_q; t.column = pcol;
            t.offset = poff; t.length = 21'd1;
          end
          job.tok0 = t;
        end
        default: mode_d = M_ERR;
      endcase

      if (done) begin
        job.count = 2'd1; job.tok0 = t; mode_d = M_IDLE;
      end

      // Start of a new token from idle, or right after a closed one.
      if (mode_q == M_IDLE || done) begin
        nm = M_IDLE;
        if (!is_blank(c)) begin
          t = '0;
          t.line = line_q; t.column = col_q; t.offset = off_q; t.length = 21'd1;
          sline_d = line_q; scol_d = col_q; soff_d = off_q;
          sk = single_kind(c);
          if (is_digit(c)) begin
            acc_d = {59'd0, d4}; nm = M_NUM;
          end else if (is_alpha(c)) begin
            kw_d = {56'd0, c}; kwl_d = 4'd1; nm = M_IDENT;
          end else if (c == 8'h5f) nm = M_UNDER;
          else if (is_held_op(c)) begin
            held_d = c; nm = M_OP;
          end else begin
            if (sk != 6'd0) begin
              t.kind = sk; if (sk == K_CARET) t.value = 63'd1;
            end else begin
              t.kind = K_ERROR;
              t.err = (c == 8'h22 || c == 8'h27) ? E_QUOTE : E_CHAR;
              nm = M_ERR;
            end
            if (done) begin job.count = 2'd2; job.tok1 = t; end
            else begin job.count = 2'd1; job.tok0 = t; end
          end
        end
        mode_d = nm;
      end

      // Position tracking.
      if (off_q < OFF_MAX) off_d = off_q + 20'd1;
      if (c == 8'h0a) begin
        if (line_q < POS_MAX) line_d = line_q + 21'd1;
        col_d = 21'd1;
      end else if (col_q < POS_MAX) col_d = col_q + 21'd1;
    end else if (end_of_source_i) begin
      // Flush the pending token, then the end token unless the flush failed.
      t.line = sline_q; t.column = scol_q; t.offset = soff_q;
      t.length = {1'b0, off_q - soff_q};
      done = 1'b1;
      unique case (mode_q)
        M_NUM: begin t.kind = K_INT; t.value = acc_q; end
        M_NUM_OVF: begin t.kind = K_ERROR; t.err = E_OVF; end
        M_NUM_DOT: begin t.kind = K_INT; t.value = acc_q; t.length = {1'b0, plen}; end
        M_NUM_DOT_OVF: begin
          t.kind = K_ERROR; t.err = E_OVF; t.length = {1'b0, plen};
        end
        M_FRAC: t.kind = K_FLOAT;
        M_IDENT: begin
          t.kind = kw_kind(kw_q, kwl_q); if (t.kind == K_TRUE) t.value = 63'd1;
        end
        M_UNDER: t.kind = K_UNDER;
        M_OP: begin
          t.length = 21'd1;
          unique case (held_q)
            8'h3c: t.kind = K_LT;
            8'h2d: t.kind = K_MINUS;
            8'h3e: t.kind = K_GT;
            8'h21: t.kind = K_NOT;
            8'h5b: t.kind = K_LBRK;
            8'h3d: begin t.kind = K_ERROR; t.err = E_EQ; end
            8'h26: begin t.kind = K_ERROR; t.err = E_AMP; end
            default: begin t.kind = K_ERROR; t.err = E_BAR; end
          endcase
        end
        M_BIN: begin t.kind = K_ERROR; t.err = E_UNCLOSE; end
        M_BIN_COLON: begin
          t.kind = K_ERROR; t.err = E_BINCHAR; t.line = line_q; t.column = pcol;
          t.offset = poff; t.length = 21'd1;
        end
        default: done = 1'b0;
      endcase
      job.tok1 = '0;
      job.tok1.kind = K_END; job.tok1.line = line_q; job.tok1.column = col_q;
      job.tok1.offset = off_q;
      if (mode_q == M_NUM_DOT) begin
        job.count = 2'd2; job.tok0 = t;
        job.tok1.kind = K_ERROR; job.tok1.err = E_CHAR; job.tok1.column = pcol;
        job.tok1.offset = poff; job.tok1.length = 21'd1;
      end else if (!done) begin
        job.count = 2'd1; job.tok0 = job.tok1;
      end else if (t.kind == K_ERROR) begin
        job.count = 2'd1; job.tok0 = t;
      end else begin
        job.count = 2'd2; job.tok0 = t;
      end
      mode_d = M_IDLE; held_d = '0; line_d = 21'd1; col_d = 21'd1; off_d = '0;
      sline_d = 21'd1; scol_d = 21'd1; soff_d = '0; acc_d = '0; kw_d = '0;
      kwl_d = '0; bits_d = '0; phase_d = '0;
    end

    // Mark the final token of this request.
    if (job.count == 2'd2) job.tok1.last = 1'b1;
    else job.tok0.last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE; held_q <= '0; line_q <= 21'd1; col_q <= 21'd1; off_q <= '0;
      sline_q <= 21'd1; scol_q <= 21'd1; soff_q <= '0; acc_q <= '0; kw_q <= '0;
      kwl_q <= '0; bits_q <= '0; phase_q <= '0;
    end else if (fire) begin
      mode_q <= mode_d; held_q <= held_d; line_q <= line_d; col_q <= col_d;
      off_q <= off_d; sline_q <= sline_d; scol_q <= scol_d; soff_q <= soff_d;
      acc_q <= acc_d; kw_q <= kw_d; kwl_q <= kwl_d; bits_q <= bits_d;
      phase_q <= phase_d;
    end
  end

  // The end marker always yields at least one token.
  a_eos_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && end_of_source_i |-> job_valid_o) else $error("end marker gave no token");
  // The end marker returns the scanner to idle.
  a_eos_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && end_of_source_i |=> mode_q == M_IDLE && off_q == 20'd0)
    else $error("state not cleared after end marker");
  // Nothing is emitted while the error is sticky, except at the end marker.
  a_err_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && mode_q == M_ERR && !end_of_source_i |-> !job_valid_o)
    else $error("token emitted in sticky error");
endmodule

FILE: design/stt_back.sv
module stt_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  output logic          job_ready_o,
  input  stt_pkg::job_t job_i,
  output logic          tok_valid_o,
  input  logic          tok_ready_i,
  output stt_pkg::token_t tok_o
);
  import stt_pkg::*;

  // Four-entry token queue; a request pushes one or two tokens.
  token_t     fifo_q [4];
  logic [1:0] wp_q, rp_q;
  logic [2:0] cnt_q, cnt_d;
  logic       push, pop;

  assign job_ready_o = cnt_q <= 3'd2;
  assign push        = job_valid_i && job_ready_o;
  assign tok_valid_o = cnt_q != 3'd0;
  assign pop         = tok_valid_o && tok_ready_i;
  assign tok_o       = fifo_q[rp_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push) cnt_d = cnt_d + {1'b0, job_i.count};
    if (pop) cnt_d = cnt_d - 3'd1;
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wp_q] <= job_i.tok0;
      if (job_i.count == 2'd2) fifo_q[wp_q + 2'd1] <= job_i.tok1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (push) wp_q <= wp_q + job_i.count;
      if (pop) rp_q <= rp_q + 2'd1;
      cnt_q <= cnt_d;
    end
  end

  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 3'd4)
    else $error("token queue overflow");
  a_count_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_i |-> job_i.count == 2'd1 || job_i.count == 2'd2)
    else $error("bad token count");
  a_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q[1:0] == 2'(wp_q - rp_q)) else $error("queue pointers disagree with count");
endmodule

FILE: design/source_text_tokenizer.sv
// Streaming source tokenizer.
// The in channel carries one source byte per request, or an end marker
// (end_of_source = 1) that flushes the pending token, emits an end token unless
// that gave an error, and returns all counters to line 1, column 1, offset 0.
// The out channel carries tokens: kind, error code, value, start position,
// length, and last_of_run on the final token caused by one input request.
// Each byte is classified in the cycle it is accepted; its tokens (zero, one
// or two) land in a four-entry queue and appear on the out channel in the
// next cycle at the earliest. One byte is accepted per cycle while the queue has
// room for two tokens, and one token leaves per cycle while out.ready is high,
// set by the single queue read port.
// If the receiver stalls, the queue fills and in.ready drops when fewer
// than two entries are free; nothing is lost.
// Reset clears the scanner state and empties the queue.
module source_text_tokenizer #(
  parameter int unsigned SOURCE_BYTES  = 1048576,
  parameter int unsigned KEYWORD_CHARS = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  stt_in_if.sink    in_if,
  stt_out_if.source out_if
);
  import stt_pkg::*;

  job_t   job;
  logic   job_valid, job_ready;
  token_t tok;

  stt_front #(.SOURCE_BYTES(SOURCE_BYTES), .KEYWORD_CHARS(KEYWORD_CHARS)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .char_byte_i(in_if.char_byte), .end_of_source_i(in_if.end_of_source),
    .job_valid_o(job_valid), .job_ready_i(job_ready), .job_o(job)
  );

  stt_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i(job_valid), .job_ready_o(job_ready), .job_i(job),
    .tok_valid_o(out_if.valid), .tok_ready_i(out_if.ready), .tok_o(tok)
  );

  assign out_if.token_kind   = tok.kind;
  assign out_if.error_code   = tok.err;
  assign out_if.token_value  = tok.value;
  assign out_if.start_line   = tok.line;
  assign out_if.start_column = tok.column;
  assign out_if.start_offset = tok.offset;
  assign out_if.token_length = tok.length;
  assign out_if.last_of_run  = tok.last;

  // Keyword matching covers eight characters in this build.
  a_kw_chars: assert property (@(posedge clk_i) disable iff (!rst_ni)
    KEYWORD_CHARS >= 8) else $error("unsupported keyword width");
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid) else $error("token dropped");
  a_last_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.token_kind == K_END |-> out_if.last_of_run)
    else $error("end token not last");
endmodule

FILE: tb/sv/source_text_tokenizer_tb.sv
`timescale 1ns / 1ps

module source_text_tokenizer_tb;
  import stt_pkg::*;

  // Token kinds that the package leaves unnamed.
  localparam logic [5:0] KD_INT_KW = 6'd4,  KD_FLOAT_KW = 6'd5,  KD_BOOL = 6'd6;
  localparam logic [5:0] KD_STR = 6'd7,     KD_BYTE = 6'd8,      KD_VOID = 6'd9;
  localparam logic [5:0] KD_BREAK = 6'd10,  KD_CONT = 6'd11,     KD_EXIT = 6'd12;
  localparam logic [5:0] KD_FALSE = 6'd14;
  localparam logic [5:0] KD_AT = 6'd18,     KD_HASH = 6'd19,     KD_LARROW = 6'd21;
  localparam logic [5:0] KD_LTQ = 6'd22,    KD_LE = 6'd23,       KD_RARROW = 6'd25;
  localparam logic [5:0] KD_SHR = 6'd27,    KD_GE = 6'd28,       KD_QUEST = 6'd30;
  localparam logic [5:0] KD_TILDE = 6'd31,  KD_RBRK = 6'd33,     KD_LPAR = 6'd34;
  localparam logic [5:0] KD_RPAR = 6'd35,   KD_SEMI = 6'd36,     KD_COMMA = 6'd37;
  localparam logic [5:0] KD_PLUS = 6'd38,   KD_STAR = 6'd39,     KD_SLASH = 6'd40;
  localparam logic [5:0] KD_PCT = 6'd41,    KD_EQEQ = 6'd42,     KD_NE = 6'd43;
  localparam logic [5:0] KD_ANDAND = 6'd45, KD_OROR = 6'd46;
  localparam longint unsigned VAL_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam longint unsigned OFFSET_CAP = 64'd1048575;

  localparam logic [63:0] W_INT = "int", W_FLOAT = "float", W_BOOL = "bool";
  localparam logic [63:0] W_STR = "str", W_BYTE = "byte", W_VOID = "void";
  localparam logic [63:0] W_BREAK = "break", W_CONT = "continue", W_EXIT = "exit";
  localparam logic [63:0] W_TRUE = "true", W_FALSE = "false", W_V = "v";

  typedef struct {
    logic [7:0] ch;
    logic       eos;
  } src_item_t;

  logic clk_i;
  logic rst_ni;
  stt_in_if  in_ch ();
  stt_out_if out_ch ();

  source_text_tokenizer uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  src_item_t source_queue[$];
  token_t    expected_tokens[$];
  token_t    step_tokens[$];
  bit        stimulus_done;
  bit        any_error;
  int        sent_count;
  int        hold_left;
  bit        hold_done;

  // Lexer state mirrored for prediction.
  mode_e           lx_mode;
  logic [7:0]      lx_held;
  longint unsigned lx_line, lx_col, lx_off;
  longint unsigned lx_tline, lx_tcol, lx_toff;
  longint unsigned lx_acc;
  logic [63:0]     lx_word;
  int              lx_wlen;
  logic [7:0]      lx_bits;
  int              lx_nbits;

  function automatic bit dig(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit wordch(logic [7:0] c);
    return dig(c) || alpha(c) || c == "_";
  endfunction

  function automatic bit blank(logic [7:0] c);
    return c == " " || c == 8'h09 || c == 8'h0d || c == 8'h0a;
  endfunction

  function automatic void lexer_clear();
    lx_mode = M_IDLE;
    lx_held = 8'h00;
    lx_line = 1; lx_col = 1; lx_off = 0;
    lx_tline = 1; lx_tcol = 1; lx_toff = 0;
    lx_acc = 0; lx_word = 0; lx_wlen = 0;
    lx_bits = 0; lx_nbits = 0;
  endfunction

  function automatic void emit(logic [5:0] k, logic [3:0] e, longint unsigned v,
                               longint unsigned ln, longint unsigned co,
                               longint unsigned of, longint unsigned len);
    token_t t;
    if (step_tokens.size() >= 2) return;
    t.kind = k; t.err = e; t.value = v[62:0];
    t.line = ln[20:0]; t.column = co[20:0]; t.offset = of[19:0];
    t.length = len[20:0]; t.last = 1'b0;
    step_tokens = {step_tokens, t};
  endfunction

  function automatic longint unsigned span(longint unsigned e);
    return e > lx_toff ? e - lx_toff : 0;
  endfunction

  function automatic longint unsigned prior_col();
    return lx_col > 1 ? lx_col - 1 : 1;
  endfunction

  function automatic longint unsigned prior_off();
    return lx_off > 0 ? lx_off - 1 : 0;
  endfunction

  function automatic void emit_tok(logic [5:0] k, longint unsigned v, longint unsigned e);
    emit(k, E_NONE, v, lx_tline, lx_tcol, lx_toff, span(e));
    lx_mode = M_IDLE;
  endfunction

  function automatic void emit_fail(logic [3:0] code, longint unsigned e);
    emit(K_ERROR, code, 0, lx_tline, lx_tcol, lx_toff, span(e));
    lx_mode = M_ERR;
  endfunction

  function automatic void emit_fail_at(logic [3:0] code, longint unsigned ln,
                                       longint unsigned co, longint unsigned of);
    emit(K_ERROR, code, 0, ln, co, of, 1);
    lx_mode = M_ERR;
  endfunction

  // Identifier end: keywords only match short words exactly.
  function automatic void close_word();
    logic [5:0] k;
    k = K_IDENT;
    if (lx_wlen == 1 && lx_word == W_V) k = KD_FALSE;
    else if (lx_wlen == 3 && lx_word == W_INT) k = KD_INT_KW;
    else if (lx_wlen == 3 && lx_word == W_STR) k = KD_STR;
    else if (lx_wlen == 4 && lx_word == W_BOOL) k = KD_BOOL;
    else if (lx_wlen == 4 && lx_word == W_BYTE) k = KD_BYTE;
    else if (lx_wlen == 4 && lx_word == W_VOID) k = KD_VOID;
    else if (lx_wlen == 4 && lx_word == W_EXIT) k = KD_EXIT;
    else if (lx_wlen == 4 && lx_word == W_TRUE) k = K_TRUE;
    else if (lx_wlen == 5 && lx_word == W_FLOAT) k = KD_FLOAT_KW;
    else if (lx_wlen == 5 && lx_word == W_BREAK) k = KD_BREAK;
    else if (lx_wlen == 5 && lx_word == W_FALSE) k = KD_FALSE;
    else if (lx_wlen == 8 && lx_word == W_CONT) k = KD_CONT;
    emit_tok(k, k == K_TRUE ? 1 : 0, lx_off);
  endfunction

  function automatic void word_add(logic [7:0] c);
    if (lx_wlen < 8) lx_word = {lx_word[55:0], c};
    if (lx_wlen < 9) lx_wlen++;
  endfunction

  // A held operator that found no partner.
  function automatic void held_alone();
    longint unsigned e;
    e = lx_toff + 1;
    case (lx_held)
      "<": emit_tok(K_LT, 0, e);
      "-": emit_tok(K_MINUS, 0, e);
      ">": emit_tok(K_GT, 0, e);
      "!": emit_tok(K_NOT, 0, e);
      "[": emit_tok(K_LBRK, 0, e);
      "=": emit_fail(E_EQ, e);
      "&": emit_fail(E_AMP, e);
      default: emit_fail(E_BAR, e);
    endcase
  endfunction

  function automatic void start_token(logic [7:0] c);
    logic [5:0] k;
    if (blank(c)) return;
    lx_tline = lx_line; lx_tcol = lx_col; lx_toff = lx_off;
    if (dig(c)) begin
      lx_acc = c - "0";
      lx_mode = M_NUM;
      return;
    end
    if (alpha(c)) begin
      lx_word = 0; lx_wlen = 0;
      word_add(c);
      lx_mode = M_IDENT;
      return;
    end
    k = K_END;
    case (c)
      "_": begin lx_mode = M_UNDER; return; end
      "\"", "'": begin emit_fail_at(E_QUOTE, lx_line, lx_col, lx_off); return; end
      "<", "-", ">", "=", "!", "&", "|", "[": begin
        lx_held = c;
        lx_mode = M_OP;
        return;
      end
      "@": k = KD_AT;
      "#": k = KD_HASH;
      "^": k = K_CARET;
      "?": k = KD_QUEST;
      "~": k = KD_TILDE;
      "]": k = KD_RBRK;
      "(": k = KD_LPAR;
      ")": k = KD_RPAR;
      ";": k = KD_SEMI;
      ",": k = KD_COMMA;
      "+": k = KD_PLUS;
      "*": k = KD_STAR;
      "/": k = KD_SLASH;
      "%": k = KD_PCT;
      default: begin emit_fail_at(E_CHAR, lx_line, lx_col, lx_off); return; end
    endcase
    emit_tok(k, k == K_CARET ? 1 : 0, lx_off + 1);
  endfunction

  function automatic void scan_byte(logic [7:0] c);
    logic [5:0] two;
    longint unsigned d;
    two = K_END;
    case (lx_mode)
      M_IDLE: start_token(c);
      M_NUM, M_NUM_OVF: begin
        if (dig(c)) begin
          d = c - "0";
          if (lx_mode == M_NUM) begin
            if (lx_acc > (VAL_MAX - d) / 10) lx_mode = M_NUM_OVF;
            else lx_acc = lx_acc * 10 + d;
          end
        end else if (c == ".") begin
          lx_mode = (lx_mode == M_NUM) ? M_NUM_DOT : M_NUM_DOT_OVF;
        end else if (lx_mode == M_NUM_OVF) begin
          emit_fail(E_OVF, lx_off);
        end else begin
          emit_tok(K_INT, lx_acc, lx_off);
          start_token(c);
        end
      end
      M_NUM_DOT, M_NUM_DOT_OVF: begin
        if (dig(c)) lx_mode = M_FRAC;
        else if (lx_mode == M_NUM_DOT_OVF) emit_fail(E_OVF, prior_off());
        else begin
          emit_tok(K_INT, lx_acc, prior_off());
          emit_fail_at(E_CHAR, lx_line, prior_col(), prior_off());
        end
      end
      M_FRAC: begin
        if (!dig(c)) begin
          emit_tok(K_FLOAT, 0, lx_off);
          start_token(c);
        end
      end
      M_IDENT: begin
        if (wordch(c)) word_add(c);
        else begin
          close_word();
          start_token(c);
        end
      end
      M_UNDER: begin
        if (wordch(c)) begin
          lx_word = 0; lx_wlen = 0;
          word_add("_");
          word_add(c);
          lx_mode = M_IDENT;
        end else begin
          emit_tok(K_UNDER, 0, lx_off);
          start_token(c);
        end
      end
      M_OP: begin
        case (lx_held)
          "<": two = c == "-" ? KD_LARROW : c == "?" ? KD_LTQ : c == "=" ? KD_LE : K_END;
          "-": two = c == ">" ? KD_RARROW : K_END;
          ">": two = c == ">" ? KD_SHR : c == "=" ? KD_GE : K_END;
          "=": two = c == "=" ? KD_EQEQ : K_END;
          "!": two = c == "=" ? KD_NE : K_END;
          "&": two = c == "&" ? KD_ANDAND : K_END;
          "|": two = c == "|" ? KD_OROR : K_END;
          default: begin
            if (c == ":") begin
              lx_bits = 0; lx_nbits = 0;
              lx_mode = M_BIN;
              return;
            end
          end
        endcase
        if (two != K_END) emit_tok(two, 0, lx_off + 1);
        else begin
          held_alone();
          if (lx_mode != M_ERR) start_token(c);
        end
      end
      M_BIN: begin
        if (c == ":") lx_mode = M_BIN_COLON;
        else if (c == "0" || c == "1") begin
          lx_bits = {lx_bits[6:0], c == "1"};
          lx_nbits++;
          if (lx_nbits >= 8) begin
            emit(K_SBYTE, E_NONE, lx_bits, lx_tline, lx_tcol, lx_toff, span(lx_off + 1));
            lx_nbits = 0; lx_bits = 0;
          end
        end else if (!blank(c)) emit_fail_at(E_BINCHAR, lx_line, lx_col, lx_off);
      end
      M_BIN_COLON: begin
        if (c == "]") begin
          if (lx_nbits != 0) emit_fail(E_BITCNT, lx_off + 1);
          else emit_tok(K_SEND, 0, lx_off + 1);
        end else emit_fail_at(E_BINCHAR, lx_line, prior_col(), prior_off());
      end
      default: lx_mode = M_ERR;
    endcase
  endfunction

  function automatic void flush_pending();
    case (lx_mode)
      M_NUM: emit_tok(K_INT, lx_acc, lx_off);
      M_NUM_OVF: emit_fail(E_OVF, lx_off);
      M_NUM_DOT: begin
        emit_tok(K_INT, lx_acc, prior_off());
        emit_fail_at(E_CHAR, lx_line, prior_col(), prior_off());
      end
      M_NUM_DOT_OVF: emit_fail(E_OVF, prior_off());
      M_FRAC: emit_tok(K_FLOAT, 0, lx_off);
      M_IDENT: close_word();
      M_UNDER: emit_tok(K_UNDER, 0, lx_off);
      M_OP: held_alone();
      M_BIN: emit_fail(E_UNCLOSE, lx_off);
      M_BIN_COLON: emit_fail_at(E_BINCHAR, lx_line, prior_col(), prior_off());
      default: ;
    endcase
  endfunction

  // Predict the tokens of one accepted request and queue them.
  function automatic void predict_tokens(src_item_t it);
    bit was_err;
    step_tokens.delete();
    if (it.eos) begin
      was_err = lx_mode == M_ERR;
      if (!was_err) flush_pending();
      if (was_err || lx_mode != M_ERR) emit(K_END, E_NONE, 0, lx_line, lx_col, lx_off, 0);
      lexer_clear();
    end else if (lx_mode != M_ERR) begin
      scan_byte(it.ch);
      if (lx_off < OFFSET_CAP) lx_off++;
      if (it.ch == 8'h0a) begin
        if (lx_line < POS_MAX) lx_line++;
        lx_col = 1;
      end else if (lx_col < POS_MAX) lx_col++;
    end
    if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
    expected_tokens = {expected_tokens, step_tokens};
  endfunction

  // Stimulus building blocks.
  task automatic put_byte(logic [7:0] c);
    src_item_t it;
    it.ch = c; it.eos = 1'b0;
    source_queue = {source_queue, it};
  endtask

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  task automatic put_end();
    src_item_t it;
    it.ch = 8'($urandom); it.eos = 1'b1;
    source_queue = {source_queue, it};
  endtask

  task automatic put_binary(int nbits, bit good_close);
    put_text("[:");
    for (int i = 0; i < nbits; i++) begin
      put_byte($urandom_range(0, 1) ? "1" : "0");
      if ($urandom_range(0, 9) == 0) put_byte(" ");
    end
    if (good_close) put_text(":]");
    else if ($urandom_range(0, 1)) put_text(":x");
  endtask

  task automatic put_fragment();
    string kws[12];
    string ops[20];
    int n;
    kws = '{"int", "float", "bool", "str", "byte", "void", "true", "false", "v",
            "break", "continue", "exit"};
    ops = '{"<-", "<?", "<=", "<", "->", "-", ">>", ">=", ">", "==", "!=", "!",
            "&&", "||", "@", "#", "^", "?", "~", "(;),+*/%]"};
    case ($urandom_range(0, 19))
      0, 1: begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) put_byte(8'("0" + $urandom_range(0, 9)));
      end
      2: begin
        case ($urandom_range(0, 3))
          0: put_text("9223372036854775807");
          1: put_text("9223372036854775808");
          default: begin
            n = $urandom_range(17, 22);
            for (int i = 0; i < n; i++) put_byte(8'("0" + $urandom_range(0, 9)));
          end
        endcase
        if ($urandom_range(0, 2) == 0) put_text(".5");
      end
      3: begin
        put_byte(8'("0" + $urandom_range(0, 9)));
        put_byte(".");
        if ($urandom_range(0, 3) != 0) put_byte(8'("0" + $urandom_range(0, 9)));
      end
      4, 5: put_text(kws[$urandom_range(0, 11)]);
      6, 7: begin
        n = $urandom_range(1, 11);
        for (int i = 0; i < n; i++) begin
          case ($urandom_range(0, 3))
            0: put_byte(8'("A" + $urandom_range(0, 25)));
            1: put_byte(8'("0" + $urandom_range(0, 9)));
            2: put_byte("_");
            default: put_byte(8'("a" + $urandom_range(0, 25)));
          endcase
        end
      end
      8, 9, 10, 11: put_text(ops[$urandom_range(0, 19)]);
      12, 13: put_binary(8 * $urandom_range(0, 3), 1'b1);
      14: put_binary($urandom_range(1, 20), 1'($urandom_range(0, 1)));
      15: put_byte(8'h0a);
      16: put_byte("_");
      17: put_byte(8'($urandom));
      default: put_text("=&|\"'");
    endcase
  endtask

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Reset, then stimulus.
  initial begin
    int nfrag;
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.char_byte = 8'h00;
    in_ch.end_of_source = 1'b0;
    out_ch.ready = 1'b0;
    stimulus_done = 1'b0;
    any_error = 1'b0;
    sent_count = 0;
    hold_left = 0;
    hold_done = 1'b0;
    lexer_clear();

    // Directed: extremes of the byte, number corner cases, binary literals, words and a lone =.
    put_text("_a v 12.x"); put_end();
    put_byte(8'hFF); put_end();
    put_byte(8'h00); put_end();
    put_text("[:01000001:]"); put_end();
    put_text("[:0101:]"); put_end();
    put_text("= "); put_end();
    put_text("92233720368547758080 1.25"); put_end();
    put_end();

    while (source_queue.size() < 1250) begin
      nfrag = $urandom_range(1, 8);
      for (int i = 0; i < nfrag; i++) begin
        put_fragment();
        case ($urandom_range(0, 3))
          0: ;
          1: put_byte(8'h0a);
          2: put_byte(8'h09);
          default: put_byte(" ");
        endcase
      end
      put_end();
    end
    stimulus_done = 1'b1;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic int send_idle_pct(int n);
    if (n >= 250 && n < 500) return 62;
    if (n >= 750 && n < 1000) return 14;
    return 0;
  endfunction

  function automatic int recv_stall_pct(int n);
    if (n >= 500 && n < 750) return 62;
    if (n >= 750 && n < 1000) return 14;
    return 0;
  endfunction

  // Request driver; accepted requests feed the predictor.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        src_item_t it;
        it.ch = in_ch.char_byte;
        it.eos = in_ch.end_of_source;
        predict_tokens(it);
        sent_count <= sent_count + 1;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (source_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct(sent_count)) begin
          src_item_t nx;
          nx = source_queue.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.char_byte <= nx.ch;
          in_ch.end_of_source <= nx.eos;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string name, logic [62:0] want, logic [62:0] got);
    if (want !== got) begin
      $error("token field %s: expected %0h, got %0h", name, want, got);
      any_error = 1'b1;
    end
  endfunction

  // Long hold-off counter, started once the sender is running flat out.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!hold_done && sent_count >= 1000) begin
        hold_done <= 1'b1;
        hold_left <= 300;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
      end
    end
  end

  // Token monitor and receiver back-pressure.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_tokens.size() == 0) begin
          $error("token with kind %0d arrived with none expected", out_ch.token_kind);
          any_error = 1'b1;
        end else begin
          token_t w;
          w = expected_tokens.pop_front();
          check_field("token_kind", w.kind, out_ch.token_kind);
          check_field("error_code", w.err, out_ch.error_code);
          check_field("token_value", w.value, out_ch.token_value);
          check_field("start_line", w.line, out_ch.start_line);
          check_field("start_column", w.column, out_ch.start_column);
          check_field("start_offset", w.offset, out_ch.start_offset);
          check_field("token_length", w.length, out_ch.token_length);
          check_field("last_of_run", w.last, out_ch.last_of_run);
        end
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= $urandom_range(0, 99) >= recv_stall_pct(sent_count);
      end
    end
  end

  // End of run.
  initial begin
    wait (stimulus_done && rst_ni);
    while (source_queue.size() > 0 || in_ch.valid) @(posedge clk_i);
    while (expected_tokens.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (!any_error && expected_tokens.size() == 0) begin
      $display("source_text_tokenizer_tb: clean");
    end else begin
      $display("source_text_tokenizer_tb: errors");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5_000_000;
    $display("source_text_tokenizer_tb: errors");
    $finish;
  end

endmodule
